@@ rtl/fci_pkg.sv @@
package fci_pkg;

  // Store geometry.
  localparam int ADDR_BITS_DEF = 16;
  localparam int SECTOR_BITS   = 8;
  localparam int BUS_ADDR_BITS = 16;

  localparam logic [7:0] ERASED_BYTE = 8'hFF;

  // Command bytes of the two-write command sequences.
  localparam logic [7:0] CMD_ERASE_SETUP   = 8'h20;
  localparam logic [7:0] CMD_ERASE_CONFIRM = 8'hD0;
  localparam logic [7:0] CMD_PROGRAM_SETUP = 8'h10;

  // Final read addresses, first address and length of the protection sequence.
  localparam logic [15:0] SEQ_UNPROTECT = 16'h041a;
  localparam logic [15:0] SEQ_PROTECT   = 16'h040a;
  localparam logic [15:0] SEQ_FIRST     = 16'h1823;
  localparam logic [2:0]  SEQ_LEN       = 3'd6;

  // Address expected at each step of the protection sequence.
  function automatic logic [15:0] seq_addr(input logic [2:0] step);
    logic [15:0] a;
    unique case (step)
      3'd0:    a = 16'h1823;
      3'd1:    a = 16'h1820;
      3'd2:    a = 16'h1822;
      3'd3:    a = 16'h0418;
      3'd4:    a = 16'h041b;
      3'd5:    a = 16'h0419;
      default: a = SEQ_FIRST;
    endcase
    return a;
  endfunction

  // Controller states, one-hot.
  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_PGM    = 5'b00100,
    S_ERASE  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  // Command phase of the write sequence.
  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_ERASE   = 2'd1,
    PH_PROGRAM = 2'd2
  } phase_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic clear_step;
    logic erase_step;
    logic pgm_write;
    logic out_load;
    logic protect;
    logic rejected;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clear_last;
    logic sector_last;
    logic out_free;
  } dp_status_t;

endpackage

@@ rtl/fci_datapath.sv @@
module fci_datapath
  import fci_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_mode,
  input  logic [BUS_ADDR_BITS-1:0] in_address,
  input  logic [7:0]               in_write_data,
  input  ctrl_cmd_t                cmd,
  output dp_status_t               status,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [7:0]               out_read_data,
  output logic                     out_protect_on,
  output logic                     out_rejected
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [7:0] mem [DEPTH];

  logic [ADDR_BITS-1:0]                 addr_r;
  logic [7:0]                           data_r;
  logic                                 mode_r;
  logic [7:0]                           rd_data_r;
  logic [ADDR_BITS-1:0]                 sweep_cnt_r;
  logic                                 out_valid_r;
  logic [7:0]                           out_read_data_r;
  logic                                 out_protect_r;
  logic                                 out_rejected_r;

  logic [ADDR_BITS+BUS_ADDR_BITS-1:0]   addr_ext;
  logic [ADDR_BITS-1:0]                 idx_in;
  logic                                 we;
  logic [ADDR_BITS-1:0]                 waddr;
  logic [7:0]                           wdata;

  // Bus address bits above the store size are dropped; a narrow bus is zero-extended.
  assign addr_ext = {{ADDR_BITS{1'b0}}, in_address};
  assign idx_in   = addr_ext[ADDR_BITS-1:0];

  // Capture the request.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr_r <= idx_in;
      data_r <= in_write_data;
      mode_r <= in_mode;
    end
  end

  // Write port select: clearing sweep, sector erase sweep or program.
  always_comb begin
    we    = 1'b0;
    waddr = addr_r;
    wdata = ERASED_BYTE;
    priority if (cmd.clear_step) begin
      we    = 1'b1;
      waddr = sweep_cnt_r;
    end else if (cmd.erase_step) begin
      we    = 1'b1;
      waddr = {addr_r[ADDR_BITS-1:SECTOR_BITS], sweep_cnt_r[SECTOR_BITS-1:0]};
    end else if (cmd.pgm_write) begin
      we    = 1'b1;
      wdata = rd_data_r & data_r;
    end else begin
      // No store write this cycle.
      we    = 1'b0;
    end
  end

  // Store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.capture) begin
      rd_data_r <= mem[idx_in];
    end
  end

  // Sweep counter for the clearing pass and the sector erase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_cnt_r <= '0;
    end else if (cmd.capture) begin
      sweep_cnt_r <= '0;
    end else if (cmd.clear_step || cmd.erase_step) begin
      sweep_cnt_r <= sweep_cnt_r + 1'b1;
    end
  end

  assign status.clear_last  = &sweep_cnt_r;
  assign status.sector_last = &sweep_cnt_r[SECTOR_BITS-1:0];
  assign status.out_free    = !out_valid_r || out_ready;

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_read_data_r <= mode_r ? 8'h00 : rd_data_r;
      out_protect_r   <= cmd.protect;
      out_rejected_r  <= cmd.rejected;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = out_read_data_r;
  assign out_protect_on = out_protect_r;
  assign out_rejected   = out_rejected_r;

endmodule

@@ rtl/fci_ctrl.sv @@
module fci_ctrl
  import fci_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_mode,
  input  logic [BUS_ADDR_BITS-1:0] in_address,
  input  logic [7:0]               in_write_data,
  input  dp_status_t               status,
  output ctrl_cmd_t                cmd
);

  state_t     state_r, state_nxt;
  phase_t     phase_r, phase_nxt;
  logic [2:0] step_r, step_nxt;
  logic       protect_r, protect_nxt;
  logic       rej_r, rej_nxt;
  logic       accept;
  logic       first_hit;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign first_hit = (in_address == SEQ_FIRST);

  // Per-state store and output commands, protection recognizer, command phase and next state.
  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    step_nxt    = step_r;
    protect_nxt = protect_r;
    rej_nxt     = rej_r;
    cmd         = '0;
    cmd.protect  = protect_r;
    cmd.rejected = rej_r;

    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          rej_nxt     = 1'b0;
          state_nxt   = S_FINISH;
          if (!in_mode) begin
            // A read cancels any armed command and advances or restarts the sequence.
            phase_nxt = PH_IDLE;
            if (step_r >= SEQ_LEN) begin
              if (in_address == SEQ_UNPROTECT) begin
                protect_nxt = 1'b0;
              end else if (in_address == SEQ_PROTECT) begin
                protect_nxt = 1'b1;
              end
              step_nxt = first_hit ? 3'd1 : 3'd0;
            end else if (in_address == seq_addr(step_r)) begin
              step_nxt = step_r + 3'd1;
            end else begin
              step_nxt = first_hit ? 3'd1 : 3'd0;
            end
          end else begin
            step_nxt  = 3'd0;
            phase_nxt = PH_IDLE;
            unique case (phase_r)
              PH_ERASE: begin
                if (in_write_data == CMD_ERASE_CONFIRM) begin
                  if (protect_r) begin
                    rej_nxt = 1'b1;
                  end else begin
                    state_nxt = S_ERASE;
                  end
                end
              end
              PH_PROGRAM: begin
                if (protect_r) begin
                  rej_nxt = 1'b1;
                end else begin
                  state_nxt = S_PGM;
                end
              end
              default: begin
                if (in_write_data == CMD_ERASE_SETUP) begin
                  phase_nxt = PH_ERASE;
                end else if (in_write_data == CMD_PROGRAM_SETUP) begin
                  phase_nxt = PH_PROGRAM;
                end
              end
            endcase
          end
        end
      end
      S_PGM: begin
        cmd.pgm_write = 1'b1;
        state_nxt     = S_FINISH;
      end
      S_ERASE: begin
        cmd.erase_step = 1'b1;
        if (status.sector_last) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      phase_r   <= PH_IDLE;
      step_r    <= 3'd0;
      protect_r <= 1'b1;
      rej_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      phase_r   <= phase_nxt;
      step_r    <= step_nxt;
      protect_r <= protect_nxt;
      rej_r     <= rej_nxt;
    end
  end

endmodule

@@ rtl/flash_command_interface.sv @@
// Channel   Dir  Ports                        Contents
// in_       in   in_tvalid/in_tready          one bus access (read or write)
// out_      out  out_tvalid/out_tready        one result per access
//
// A read or a plain write goes from capture straight to the result; a
// program reads at capture, then ANDs and writes back on the single store
// write port; a sector erase sweeps the sector, one byte per cycle.
// After reset a clearing pass writes 0xFF to all 2^ADDR_BITS bytes, one per
// cycle, with in_tready low.
// A result waits in the output register while the next request is taken;
// it stalls completion only while out_tready holds the register full.
module flash_command_interface
  import fci_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [15:0] address, [23:16] write_data
  input  logic        in_tuser,   // [0] mode: 0 read, 1 write
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [7:0] read_data, [8] protect_on, [9] rejected
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic [7:0] read_data;
  logic       protect_on;
  logic       rejected;

  // Sequencer for requests, protection and command phases.
  fci_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_mode       (in_tuser),
    .in_address    (in_tdata[15:0]),
    .in_write_data (in_tdata[23:16]),
    .status        (status),
    .cmd           (cmd)
  );

  // Store, sweep counter and output register.
  fci_datapath #(
    .ADDR_BITS (ADDR_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mode        (in_tuser),
    .in_address     (in_tdata[15:0]),
    .in_write_data  (in_tdata[23:16]),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_read_data  (read_data),
    .out_protect_on (protect_on),
    .out_rejected   (rejected)
  );

  assign out_tdata = {6'b0, rejected, protect_on, read_data};

endmodule

@@ dv/flash_command_interface_tb.sv @@
module flash_command_interface_tb;
  import fci_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_BITS = ADDR_BITS_DEF;
  localparam int SECTOR_SIZE = 1 << SECTOR_BITS;
  localparam int MAX_PRINTED = 50;

  // Read addresses of the protection sequence, step 0 in the lowest slot.
  localparam logic [5:0][15:0] UNLOCK_SEQ = {
    16'h0419, 16'h041b, 16'h0418, 16'h1822, 16'h1820, 16'h1823
  };

  typedef enum logic {
    ACC_READ  = 1'b0,
    ACC_WRITE = 1'b1
  } access_kind_t;

  typedef struct packed {
    access_kind_t mode;
    logic [15:0]  address;
    logic [7:0]   write_data;
  } bus_access_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       protect_on;
    logic       rejected;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // [15:0] address, [23:16] write_data
  logic        in_tuser = 1'b0; // [0] mode: 0 read, 1 write
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [7:0] read_data, [8] protect_on, [9] rejected

  // Pending bus accesses and the replies that accepted accesses must produce.
  bus_access_t access_q[$];
  reply_t      reply_q[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count = 0;
  logic in_fire = 1'b0;

  // Predicted device state.
  logic [7:0] flash_mem [0:(1 << STORE_BITS) - 1];
  logic [2:0] seq_step;
  phase_t     cmd_phase;
  logic       protect;

  bus_access_t drive_item;
  bus_access_t taken_item;
  reply_t      taken_reply;
  reply_t      seen_reply;

  flash_command_interface u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTED) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%02h, expected 0x%02h", name, got, want));
    end
  endtask

  // Applies one bus access to the predicted device and returns its reply.
  task automatic predict_reply(input bus_access_t acc, output reply_t rep);
    logic [STORE_BITS-1:0] idx;
    logic [STORE_BITS-1:0] base;
    idx = acc.address[STORE_BITS-1:0];
    rep = '0;
    if (acc.mode == ACC_READ) begin
      rep.read_data = flash_mem[idx];
      cmd_phase = PH_IDLE;
      // Protection recognizer: after six matched reads the seventh decides.
      if (seq_step >= SEQ_LEN) begin
        if (acc.address == SEQ_UNPROTECT) begin
          protect = 1'b0;
        end else if (acc.address == SEQ_PROTECT) begin
          protect = 1'b1;
        end
        seq_step = (acc.address == SEQ_FIRST) ? 3'd1 : 3'd0;
      end else if (acc.address == UNLOCK_SEQ[seq_step]) begin
        seq_step = seq_step + 3'd1;
      end else begin
        seq_step = (acc.address == SEQ_FIRST) ? 3'd1 : 3'd0;
      end
    end else begin
      seq_step = 3'd0;
      case (cmd_phase)
        PH_ERASE: begin
          if (acc.write_data == CMD_ERASE_CONFIRM) begin
            if (protect) begin
              rep.rejected = 1'b1;
            end else begin
              base = {idx[STORE_BITS-1:SECTOR_BITS], {SECTOR_BITS{1'b0}}};
              for (int k = 0; k < SECTOR_SIZE; k++) begin
                flash_mem[base + k] = ERASED_BYTE;
              end
            end
          end
          cmd_phase = PH_IDLE;
        end
        PH_PROGRAM: begin
          if (protect) begin
            rep.rejected = 1'b1;
          end else begin
            flash_mem[idx] = flash_mem[idx] & acc.write_data;
          end
          cmd_phase = PH_IDLE;
        end
        default: begin
          if (acc.write_data == CMD_ERASE_SETUP) begin
            cmd_phase = PH_ERASE;
          end else if (acc.write_data == CMD_PROGRAM_SETUP) begin
            cmd_phase = PH_PROGRAM;
          end else begin
            cmd_phase = PH_IDLE;
          end
        end
      endcase
    end
    rep.protect_on = protect;
  endtask

  task automatic push_access(input access_kind_t kind, input logic [15:0] addr,
                             input logic [7:0] data);
    bus_access_t acc;
    acc.mode = kind;
    acc.address = addr;
    acc.write_data = data;
    access_q.push_back(acc);
  endtask

  // An address in one of a few sectors, mostly near the sector start, so that
  // reads hit bytes that programs and erases have touched.
  function automatic logic [15:0] hot_address();
    logic [7:0] sector;
    logic [7:0] offset;
    case ($urandom_range(3))
      0: sector = 8'h00;
      1: sector = 8'h04;
      2: sector = 8'h18;
      default: sector = 8'hFF;
    endcase
    offset = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(15));
    return {sector, offset};
  endfunction

  // Six sequence reads and a final read; a step may be replaced by noise.
  task automatic queue_protect_seq(input logic [15:0] final_addr, input int break_at);
    for (int s = 0; s < 6; s++) begin
      if (s == break_at) begin
        if ($urandom_range(1) == 0) begin
          push_access(ACC_READ, 16'($urandom_range(65535)), 8'($urandom_range(255)));
        end else begin
          push_access(ACC_WRITE, 16'($urandom_range(65535)), 8'($urandom_range(255)));
        end
      end else begin
        push_access(ACC_READ, UNLOCK_SEQ[s], 8'($urandom_range(255)));
      end
    end
    push_access(ACC_READ, final_addr, 8'($urandom_range(255)));
  endtask

  // Mostly well-formed command and protection sequences with random content.
  task automatic queue_random_traffic(input int n_items);
    int start;
    int pick;
    logic [15:0] last;
    start = access_q.size();
    while (access_q.size() - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        push_access(ACC_WRITE, 16'($urandom_range(65535)), CMD_PROGRAM_SETUP);
        push_access(ACC_WRITE, hot_address(), 8'($urandom_range(255)));
      end else if (pick < 29) begin
        push_access(ACC_WRITE, 16'($urandom_range(65535)), CMD_ERASE_SETUP);
        push_access(ACC_WRITE, hot_address(), CMD_ERASE_CONFIRM);
      end else if (pick < 33) begin
        // Armed command that is dropped or cancelled.
        if ($urandom_range(1) == 0) begin
          push_access(ACC_WRITE, 16'($urandom_range(65535)), CMD_ERASE_SETUP);
          push_access(ACC_WRITE, hot_address(), 8'($urandom_range(255)));
        end else begin
          push_access(ACC_WRITE, 16'($urandom_range(65535)),
                      ($urandom_range(1) == 0) ? CMD_ERASE_SETUP : CMD_PROGRAM_SETUP);
          push_access(ACC_READ, hot_address(), 8'($urandom_range(255)));
          push_access(ACC_WRITE, hot_address(), 8'($urandom_range(255)));
        end
      end else if (pick < 55) begin
        push_access(ACC_READ, hot_address(), 8'($urandom_range(255)));
      end else if (pick < 65) begin
        push_access(ACC_READ, 16'($urandom_range(65535)), 8'($urandom_range(255)));
      end else if (pick < 75) begin
        case ($urandom_range(9))
          0, 1:    last = SEQ_PROTECT;
          2:       last = SEQ_FIRST;
          3:       last = 16'($urandom_range(65535));
          default: last = SEQ_UNPROTECT;
        endcase
        queue_protect_seq(last, ($urandom_range(3) == 0) ? int'($urandom_range(5)) : -1);
      end else if (pick < 85) begin
        push_access(ACC_WRITE, 16'($urandom_range(65535)), 8'($urandom_range(255)));
      end else begin
        // Stray reads of sequence addresses exercise mismatch and restart.
        case ($urandom_range(7))
          6:       last = SEQ_UNPROTECT;
          7:       last = SEQ_PROTECT;
          default: last = UNLOCK_SEQ[$urandom_range(5)];
        endcase
        push_access(ACC_READ, last, 8'($urandom_range(255)));
      end
    end
  endtask

  // Holds off until every queued request is accepted and every reply is in.
  task automatic wait_drained();
    while (access_q.size() != 0 || in_tvalid || reply_q.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Request driver and reply back-pressure, updated at the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (!in_tvalid || in_fire) begin
        if (access_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drive_item = access_q.pop_front();
          in_tdata <= {drive_item.write_data, drive_item.address};
          in_tuser <= drive_item.mode;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check replies first, then predict for a request taken this edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      if (out_tvalid === 1'b1 && out_tready) begin
        if (reply_q.size() == 0) begin
          report_mismatch($sformatf("unexpected reply 0x%04h", out_tdata));
        end else begin
          seen_reply = reply_q.pop_front();
          check_field("read_data", out_tdata[7:0], seen_reply.read_data);
          check_field("protect_on", {7'd0, out_tdata[8]}, {7'd0, seen_reply.protect_on});
          check_field("rejected", {7'd0, out_tdata[9]}, {7'd0, seen_reply.rejected});
        end
      end
      in_fire <= in_tvalid && (in_tready === 1'b1);
      if (in_tvalid && in_tready === 1'b1) begin
        taken_item.mode = access_kind_t'(in_tuser);
        taken_item.address = in_tdata[15:0];
        taken_item.write_data = in_tdata[23:16];
        predict_reply(taken_item, taken_reply);
        reply_q.push_back(taken_reply);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    for (int a = 0; a < (1 << STORE_BITS); a++) begin
      flash_mem[a] = ERASED_BYTE;
    end
    seq_step = 3'd0;
    cmd_phase = PH_IDLE;
    protect = 1'b1;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 10;
    recv_idle_pct = 50;

    // Erased read at the top address, then both commands refused while protected.
    push_access(ACC_READ, 16'hFFFF, 8'h00);
    push_access(ACC_WRITE, 16'h1234, CMD_PROGRAM_SETUP);
    push_access(ACC_WRITE, 16'h0010, 8'h00);
    push_access(ACC_WRITE, 16'h0000, CMD_ERASE_SETUP);
    push_access(ACC_WRITE, 16'h0010, CMD_ERASE_CONFIRM);
    // Unlock, then program the last byte of the first sector and the top byte of the store.
    queue_protect_seq(SEQ_UNPROTECT, -1);
    push_access(ACC_WRITE, 16'hFFFF, CMD_PROGRAM_SETUP);
    push_access(ACC_WRITE, 16'h00FF, 8'h5A);
    push_access(ACC_READ, 16'h00FF, 8'hFF);
    push_access(ACC_WRITE, 16'h0000, CMD_PROGRAM_SETUP);
    push_access(ACC_WRITE, 16'hFFFF, 8'h00);
    push_access(ACC_READ, 16'hFFFF, 8'h00);
    // Erase dropped by a wrong confirm byte; program cancelled by a read.
    push_access(ACC_WRITE, 16'h0000, CMD_ERASE_SETUP);
    push_access(ACC_WRITE, 16'h0080, 8'h33);
    push_access(ACC_WRITE, 16'h0000, CMD_PROGRAM_SETUP);
    push_access(ACC_READ, 16'h0000, 8'h00);
    push_access(ACC_WRITE, 16'h00FF, 8'hFF);
    // Sector erase of the top sector.
    push_access(ACC_WRITE, 16'h0000, CMD_ERASE_SETUP);
    push_access(ACC_WRITE, 16'hFFC3, CMD_ERASE_CONFIRM);
    push_access(ACC_READ, 16'hFFFF, 8'h00);
    // Lock again, with a repeated first read restarting the sequence.
    push_access(ACC_READ, SEQ_FIRST, 8'h00);
    queue_protect_seq(SEQ_PROTECT, -1);
    wait_drained();

    queue_random_traffic(420);
    wait_drained();

    send_idle_pct = 50;
    recv_idle_pct = 10;
    queue_random_traffic(420);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_traffic(420);
    wait_drained();

    // Let any stray reply show up before the verdict.
    repeat (300) @(posedge clk);
    if (error_count == 0) begin
      $display("flash_command_interface regression: pass");
    end else begin
      $display("flash_command_interface regression: fail");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #10_000_000;
    $display("flash_command_interface regression: fail");
    $finish;
  end

endmodule
